/* hw/rtl/dla_pkg.sv */
// ----------------------------------------------------------------------------
// DLA shared definitions
// Widths, codes and the command and status bundles used between the
// controller and the datapath of the aggregation engine.
// ----------------------------------------------------------------------------
package dla_pkg;

	localparam int GRID_MAX   = 64;
	localparam int COORD_W    = 6;
	localparam int ORDER_W    = 7;
	localparam int TARGET_W   = 9;
	localparam int COUNT_W    = 9;
	localparam int STATUS_W   = 3;
	localparam int OP_W       = 2;
	localparam int DIR_W      = 2;
	localparam int KIND_W     = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;
	localparam int IN_W       = 16;
	localparam int OUT_W      = 32;

	localparam logic [ORDER_W-1:0]  ORDER_RESET  = 7'd9;
	localparam logic [ORDER_W-1:0]  ORDER_MIN    = 7'd3;
	localparam logic [ORDER_W-1:0]  ORDER_MAX    = ORDER_W'(GRID_MAX);
	localparam logic [TARGET_W-1:0] TARGET_RESET = 9'd8;
	localparam logic [COORD_W-1:0]  RESET_MID    = COORD_W'(ORDER_RESET >> 1);
	localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;
	localparam logic [GRID_MAX-1:0] ROW_ONE      = GRID_MAX'(1);

	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_LAUNCH = 2'd1;
	localparam logic [OP_W-1:0] OP_STEP   = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

	localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd0;
	localparam logic [DIR_W-1:0] DIR_UP    = 2'd1;
	localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
	localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_MOVED    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_STUCK    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_LAUNCHED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FINISHED = 3'd4;
	localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_ORDER  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 1'd1;

	// How an accepted item is handled: grid clear, answered at once, or grid lookup.
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
	localparam logic [KIND_W-1:0] KIND_IMM   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MEM   = 2'd2;

	typedef struct packed {
		logic accept;
		logic clr_step;
		logic eval;
		logic set_cell;
		logic out_load;
	} dla_cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              is_step;
		logic              occupied;
		logic              clr_last;
		logic              out_busy;
	} dla_stat_t;

endpackage

/* hw/rtl/dla_ram.sv */
// ----------------------------------------------------------------------------
// DLA generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/dla_ctrl.sv */
// ----------------------------------------------------------------------------
// DLA controller
// Sequences the clearing sweep, the grid lookup and the sticking write, and
// hands each finished result to the output register.
// ----------------------------------------------------------------------------
module dla_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  dla_pkg::dla_stat_t stat,
	output dla_pkg::dla_cmd_t  cmd
);
	import dla_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CLR  = 3'd1;
	localparam logic [2:0] S_EVAL = 3'd2;
	localparam logic [2:0] S_SET  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       clr_item_q;
	logic       clr_item_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d    = state_q;
		clr_item_d = clr_item_q;
		cmd        = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					case (stat.kind)
						KIND_CLEAR: begin
							state_d    = S_CLR;
							clr_item_d = 1'b1;
						end
						KIND_MEM: state_d = S_EVAL;
						default:  state_d = S_DONE;
					endcase
				end
			end
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					// The sweep after reset has no item to answer.
					state_d    = clr_item_q ? S_DONE : S_IDLE;
					clr_item_d = 1'b0;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = (stat.is_step && stat.occupied) ? S_SET : S_DONE;
			end
			S_SET: begin
				cmd.set_cell = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_item_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			clr_item_q <= clr_item_d;
		end
	end

endmodule

/* hw/rtl/dla_dp.sv */
// ----------------------------------------------------------------------------
// DLA datapath
// Configuration, walker and count registers, the row-wide occupancy memory
// and the output register.
// ----------------------------------------------------------------------------
module dla_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dla_pkg::dla_cmd_t                 cmd,
	output dla_pkg::dla_stat_t                stat,
	input  logic                              cfg_wen,
	input  logic [dla_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dla_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [dla_pkg::IN_W-1:0]          in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [dla_pkg::OUT_W-1:0]         out_data
);
	import dla_pkg::*;

	logic [ORDER_W-1:0]  order_q;
	logic [TARGET_W-1:0] target_q;
	logic [COORD_W-1:0]  walker_r_q;
	logic [COORD_W-1:0]  walker_c_q;
	logic                active_q;
	logic [COUNT_W-1:0]  count_q;
	logic [COORD_W-1:0]  mid_q;
	logic [COORD_W-1:0]  sweep_q;
	logic                out_valid_q;

	logic                is_step_q;
	logic [COORD_W-1:0]  row_q;
	logic [COORD_W-1:0]  col_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [COORD_W-1:0]  res_row_q;
	logic [COORD_W-1:0]  res_col_q;
	logic [OUT_W-1:0]    out_data_q;

	logic [OP_W-1:0]     in_op;
	logic [COORD_W-1:0]  in_row;
	logic [COORD_W-1:0]  in_col;
	logic [DIR_W-1:0]    in_dir;

	logic [ORDER_W-1:0]  n;
	logic [ORDER_W-1:0]  n_m1;
	logic [COORD_W-1:0]  n_half;
	logic [COORD_W-1:0]  next_r;
	logic [COORD_W-1:0]  next_c;
	logic                finished_now;
	logic                range_bad;
	logic [KIND_W-1:0]   kind;

	logic                ram_we;
	logic [COORD_W-1:0]  ram_waddr;
	logic [GRID_MAX-1:0] ram_wdata;
	logic                ram_re;
	logic [COORD_W-1:0]  ram_raddr;
	logic [GRID_MAX-1:0] ram_rdata;
	logic                occupied;

	assign in_op  = in_data[1:0];
	assign in_row = in_data[7:2];
	assign in_col = in_data[13:8];
	assign in_dir = in_data[15:14];

	always_comb begin
		if (order_q < ORDER_MIN) begin
			n = ORDER_MIN;
		end else if (order_q > ORDER_MAX) begin
			n = ORDER_MAX;
		end else begin
			n = order_q;
		end
	end

	assign n_m1   = n - ORDER_W'(1);
	assign n_half = COORD_W'(n >> 1);

	// A walker left outside a shrunken grid wraps to zero on a right or down step.
	always_comb begin
		next_r = walker_r_q;
		next_c = walker_c_q;
		case (in_dir)
			DIR_RIGHT: next_c = ({1'b0, walker_c_q} >= n_m1) ? '0 : walker_c_q + COORD_W'(1);
			DIR_UP:    next_r = (walker_r_q == '0) ? n_m1[COORD_W-1:0]
				: walker_r_q - COORD_W'(1);
			DIR_LEFT:  next_c = (walker_c_q == '0) ? n_m1[COORD_W-1:0]
				: walker_c_q - COORD_W'(1);
			default:   next_r = ({1'b0, walker_r_q} >= n_m1) ? '0 : walker_r_q + COORD_W'(1);
		endcase
	end

	assign finished_now = (count_q > target_q);
	assign range_bad    = ({1'b0, in_row} >= n) || ({1'b0, in_col} >= n);

	always_comb begin
		if (in_op == OP_CLEAR) begin
			kind = KIND_CLEAR;
		end else if (in_op == OP_NONE || finished_now) begin
			kind = KIND_IMM;
		end else if (in_op == OP_LAUNCH) begin
			kind = range_bad ? KIND_IMM : KIND_MEM;
		end else begin
			kind = active_q ? KIND_MEM : KIND_IMM;
		end
	end

	assign occupied = ram_rdata[col_q];

	assign stat.kind     = kind;
	assign stat.is_step  = is_step_q;
	assign stat.occupied = occupied;
	assign stat.clr_last = (sweep_q == COORD_W'(GRID_MAX - 1));
	assign stat.out_busy = out_valid_q && !out_ready;

	// The lookup is issued as the item is taken; the evaluation cycle reads the
	// walker's own row in case it has to stick.
	assign ram_re    = cmd.accept || cmd.eval;
	assign ram_raddr = cmd.eval ? walker_r_q : ((in_op == OP_LAUNCH) ? in_row : next_r);
	assign ram_we    = cmd.clr_step || cmd.set_cell;
	assign ram_waddr = cmd.clr_step ? sweep_q : walker_r_q;

	always_comb begin
		if (cmd.clr_step) begin
			ram_wdata = (sweep_q == mid_q) ? (ROW_ONE << mid_q) : '0;
		end else begin
			ram_wdata = ram_rdata | (ROW_ONE << walker_c_q);
		end
	end

	dla_ram #(
		.WIDTH(GRID_MAX),
		.DEPTH(GRID_MAX)
	) u_grid (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q     <= ORDER_RESET;
			target_q    <= TARGET_RESET;
			walker_r_q  <= '0;
			walker_c_q  <= '0;
			active_q    <= 1'b0;
			count_q     <= '0;
			mid_q       <= RESET_MID;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					CFG_ORDER:  order_q  <= cfg_data[ORDER_W-1:0];
					CFG_TARGET: target_q <= cfg_data[TARGET_W-1:0];
					default:    order_q  <= order_q;
				endcase
			end
			if (cmd.accept && in_op == OP_CLEAR) begin
				mid_q    <= n_half;
				sweep_q  <= '0;
				count_q  <= '0;
				active_q <= 1'b0;
			end
			if (cmd.clr_step) begin
				sweep_q <= sweep_q + COORD_W'(1);
			end
			if (cmd.eval && !occupied) begin
				walker_r_q <= row_q;
				walker_c_q <= col_q;
				if (!is_step_q) begin
					active_q <= 1'b1;
				end
			end
			if (cmd.set_cell) begin
				active_q <= 1'b0;
				if (count_q != COUNT_MAX) begin
					count_q <= count_q + COUNT_W'(1);
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			is_step_q <= (in_op == OP_STEP);
			row_q     <= (in_op == OP_LAUNCH) ? in_row : next_r;
			col_q     <= (in_op == OP_LAUNCH) ? in_col : next_c;
			if (in_op == OP_CLEAR) begin
				res_status_q <= ST_CLEARED;
				res_row_q    <= n_half;
				res_col_q    <= n_half;
			end else if (in_op == OP_NONE) begin
				res_status_q <= ST_REJECTED;
				res_row_q    <= walker_r_q;
				res_col_q    <= walker_c_q;
			end else if (finished_now) begin
				res_status_q <= ST_FINISHED;
				res_row_q    <= walker_r_q;
				res_col_q    <= walker_c_q;
			end else if (in_op == OP_LAUNCH) begin
				res_status_q <= ST_REJECTED;
				res_row_q    <= in_row;
				res_col_q    <= in_col;
			end else begin
				res_status_q <= ST_REJECTED;
				res_row_q    <= walker_r_q;
				res_col_q    <= walker_c_q;
			end
		end
		if (cmd.eval) begin
			if (is_step_q) begin
				if (occupied) begin
					res_status_q <= ST_STUCK;
				end else begin
					res_status_q <= ST_MOVED;
					res_row_q    <= row_q;
					res_col_q    <= col_q;
				end
			end else if (!occupied) begin
				res_status_q <= ST_LAUNCHED;
			end
		end
		if (cmd.out_load) begin
			out_data_q <= OUT_W'({finished_now, count_q, res_col_q, res_row_q, res_status_q});
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

/* hw/rtl/dla_grid_random_walk_aggregator.sv */
// ----------------------------------------------------------------------------
// DLA grid random walk aggregator
// Diffusion-limited aggregation on a toroidal bit grid, driven by clear,
// launch and step items, with one result per item.
// ----------------------------------------------------------------------------
// Items are handled one at a time and s_axis_tready is high only while the
// engine is idle; the next item may be taken while a result still waits on
// the output. The grid is a 64 x 64 bit memory held as one 64-bit word per
// row, so a lookup costs one read and a stick costs a second read and a
// write of the walker's row. A step or launch goes from the transfer through
// the lookup evaluation to the result, a step that sticks also through the
// row write, and an item answered without a lookup straight to the result. A
// clear rewrites every row, one a cycle. After reset the same clearing pass
// runs before the first item is taken; configuration writes are taken during it.
module dla_grid_random_walk_aggregator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [dla_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dla_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// op[1:0], start_row[7:2], start_col[13:8], direction[15:14]
	input  logic [dla_pkg::IN_W-1:0]       s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// status[2:0], walker_row[8:3], walker_col[14:9], stuck_count[23:15],
	// finished[24], zero[31:25]
	output logic [dla_pkg::OUT_W-1:0]      m_axis_tdata
);
	import dla_pkg::*;

	dla_cmd_t  cmd;
	dla_stat_t stat;

	dla_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	dla_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_data  (s_axis_tdata),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (m_axis_tdata)
	);

endmodule

/* hw/rtl/dla_chk.sv */
// ----------------------------------------------------------------------------
// DLA port checker
// Watches the ports of the aggregator for handshake and result consistency.
// ----------------------------------------------------------------------------
module dla_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [dla_pkg::OUT_W-1:0]      m_axis_tdata
);
	import dla_pkg::*;

	// A result held back by the sink stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// Only one item is worked on at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second item taken while busy");

	// A cleared grid reports no stuck particles and is not finished.
	a_clear_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:0] == ST_CLEARED |->
		m_axis_tdata[23:15] == '0 && !m_axis_tdata[24])
		else $error("clear result with nonzero count");

	// A stuck walker has been counted.
	a_stuck_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:0] == ST_STUCK |-> m_axis_tdata[23:15] != '0)
		else $error("stuck result with zero count");

	// Only defined status codes leave the block; the cleared code is the highest.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2:0] <= ST_CLEARED)
		else $error("undefined status code");

endmodule

bind dla_grid_random_walk_aggregator dla_chk u_dla_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aggregation engine testbench
// Feeds clear, launch and step items through the input stream. The testbench
// keeps its own copy of the grid, the walker and the count, and works out the
// expected result of every accepted transfer. Each result from the output
// stream is compared field by field against the oldest expectation. The grid
// size and the particle target are changed only between phases, while no
// items are in flight.
// ----------------------------------------------------------------------------
module testbench;
	import dla_pkg::*;

	typedef struct packed {
		logic [DIR_W-1:0]   dir;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [OP_W-1:0]    op;
	} walk_item_t;

	typedef struct packed {
		logic [OUT_W-26:0]   pad;
		logic                finished;
		logic [COUNT_W-1:0]  count;
		logic [COORD_W-1:0]  col;
		logic [COORD_W-1:0]  row;
		logic [STATUS_W-1:0] status;
	} walk_outcome_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_wen       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = CFG_ORDER;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_W-1:0]       s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_W-1:0]      m_axis_tdata;

	dla_grid_random_walk_aggregator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Shadow state of the engine.
	logic [GRID_MAX-1:0] occupied [GRID_MAX];
	logic [COORD_W-1:0]  walk_row;
	logic [COORD_W-1:0]  walk_col;
	logic                walk_live;
	logic [COUNT_W-1:0]  stuck_total;
	logic [ORDER_W-1:0]  side_reg;
	logic [TARGET_W-1:0] target_reg;

	walk_item_t    pending_walks [$];
	walk_outcome_t expected_outcomes [$];
	walk_item_t    cur_walk;
	walk_outcome_t got_outcome;
	walk_outcome_t want_outcome;
	int            mismatch_count = 0;
	int            feed_gap = 0;
	int            sink_gap = 0;
	bit            bursts_on = 1'b1;

	int phase_side   [10] = '{7, 0, 4, 11, 5, 64, 127, 9, 5, 13};
	int phase_target [10] = '{20, 3, 511, 409, 0, 30, 10, 60, 100, 50};
	int phase_items  [10] = '{200, 180, 180, 200, 150, 80, 80, 200, 200, 250};

	function automatic int unsigned effective_side();
		if (side_reg < ORDER_MIN)
			return 32'(ORDER_MIN);
		if (side_reg > ORDER_MAX)
			return 32'(ORDER_MAX);
		return 32'(side_reg);
	endfunction

	function automatic void seed_grid();
		logic [COORD_W-1:0] mid;
		mid = COORD_W'(effective_side() / 2);
		for (int r = 0; r < GRID_MAX; r++)
			occupied[r] = '0;
		occupied[mid][mid] = 1'b1;
		stuck_total = '0;
		walk_live = 1'b0;
	endfunction

	function automatic void predict_walk(walk_item_t it);
		int unsigned        n;
		logic [COORD_W-1:0] nr;
		logic [COORD_W-1:0] nc;
		walk_outcome_t      res;
		n = effective_side();
		res = '0;
		res.row = walk_row;
		res.col = walk_col;
		if (it.op == OP_CLEAR) begin
			seed_grid();
			res.status = ST_CLEARED;
			res.row = COORD_W'(n / 2);
			res.col = COORD_W'(n / 2);
		end else if (it.op == OP_NONE) begin
			res.status = ST_REJECTED;
		end else if (stuck_total > target_reg) begin
			res.status = ST_FINISHED;
		end else if (it.op == OP_LAUNCH) begin
			res.row = it.row;
			res.col = it.col;
			if (it.row >= n || it.col >= n || occupied[it.row][it.col]) begin
				res.status = ST_REJECTED;
			end else begin
				walk_row = it.row;
				walk_col = it.col;
				walk_live = 1'b1;
				res.status = ST_LAUNCHED;
			end
		end else if (!walk_live) begin
			res.status = ST_REJECTED;
		end else begin
			nr = walk_row;
			nc = walk_col;
			// A walker left outside a shrunken grid wraps to zero going right or down.
			case (it.dir)
				DIR_RIGHT: nc = (walk_col >= n - 1) ? '0 : walk_col + 1'b1;
				DIR_UP:    nr = (walk_row == 0) ? COORD_W'(n - 1) : walk_row - 1'b1;
				DIR_LEFT:  nc = (walk_col == 0) ? COORD_W'(n - 1) : walk_col - 1'b1;
				default:   nr = (walk_row >= n - 1) ? '0 : walk_row + 1'b1;
			endcase
			if (!occupied[nr][nc]) begin
				walk_row = nr;
				walk_col = nc;
				res.status = ST_MOVED;
			end else begin
				occupied[walk_row][walk_col] = 1'b1;
				if (stuck_total != COUNT_MAX)
					stuck_total = stuck_total + 1'b1;
				walk_live = 1'b0;
				res.status = ST_STUCK;
			end
			res.row = walk_row;
			res.col = walk_col;
		end
		res.count = stuck_total;
		res.finished = stuck_total > target_reg;
		expected_outcomes.push_back(res);
	endfunction

	function automatic void queue_walk(logic [OP_W-1:0] op, logic [COORD_W-1:0] row,
			logic [COORD_W-1:0] col, logic [DIR_W-1:0] dir);
		walk_item_t it;
		it.op = op;
		it.row = row;
		it.col = col;
		it.dir = dir;
		pending_walks.push_back(it);
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	// Input side: one transfer at a time, with random hold-off bursts.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				predict_walk(cur_walk);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (feed_gap > 0) begin
					feed_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_walks.size() > 0) begin
					cur_walk = pending_walks.pop_front();
					s_axis_tdata <= cur_walk;
					s_axis_tvalid <= 1'b1;
					if (bursts_on && $urandom_range(0, 7) == 0)
						feed_gap = $urandom_range(1, 14);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output side: stalls in random bursts and checks every transfer.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_outcome = m_axis_tdata;
				if (expected_outcomes.size() == 0) begin
					$display("%0t: result with nothing expected, expected none, actual %h",
						$time, m_axis_tdata);
					mismatch_count++;
				end else begin
					want_outcome = expected_outcomes.pop_front();
					check_field("status", 32'(want_outcome.status),
						32'(got_outcome.status));
					check_field("walker_row", 32'(want_outcome.row), 32'(got_outcome.row));
					check_field("walker_col", 32'(want_outcome.col), 32'(got_outcome.col));
					check_field("stuck_count", 32'(want_outcome.count),
						32'(got_outcome.count));
					check_field("finished", 32'(want_outcome.finished),
						32'(got_outcome.finished));
				end
			end
			if (sink_gap > 0) begin
				sink_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (bursts_on && $urandom_range(0, 7) == 0)
					sink_gap = $urandom_range(1, 14);
			end
		end
	end

	task automatic set_geometry(input logic [ORDER_W-1:0] side, input logic [TARGET_W-1:0] target);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= CFG_ORDER;
		cfg_data <= CFG_DATA_W'(side);
		@(posedge clk);
		cfg_index <= CFG_TARGET;
		cfg_data <= target;
		@(posedge clk);
		cfg_wen <= 1'b0;
		side_reg = side;
		target_reg = target;
	endtask

	// Waits until every item has gone through and the engine has settled.
	task automatic drain();
		do
			@(negedge clk);
		while (pending_walks.size() != 0 || s_axis_tvalid || expected_outcomes.size() != 0);
		repeat (80) @(negedge clk);
	endtask

	// Mostly a launch followed by a long random walk; some clears and noise.
	task automatic queue_random_walks(input int total);
		int unsigned n;
		int unsigned made;
		int unsigned burst;
		int unsigned pick;
		n = effective_side();
		made = 0;
		while (made < total) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				queue_walk(OP_CLEAR, COORD_W'($urandom_range(0, 63)),
					COORD_W'($urandom_range(0, 63)), DIR_W'($urandom_range(0, 3)));
				made++;
			end else if (pick < 14) begin
				queue_walk(OP_W'($urandom_range(0, 3)), COORD_W'($urandom_range(0, 63)),
					COORD_W'($urandom_range(0, 63)), DIR_W'($urandom_range(0, 3)));
				made++;
			end else begin
				if ($urandom_range(0, 6) == 0)
					queue_walk(OP_LAUNCH, COORD_W'($urandom_range(0, 63)),
						COORD_W'($urandom_range(0, 63)), DIR_W'($urandom_range(0, 3)));
				else
					queue_walk(OP_LAUNCH, COORD_W'($urandom_range(0, n - 1)),
						COORD_W'($urandom_range(0, n - 1)), DIR_W'($urandom_range(0, 3)));
				made++;
				burst = $urandom_range(n, 6 * n);
				for (int k = 0; k < burst && made < total; k++) begin
					queue_walk(OP_STEP, COORD_W'($urandom_range(0, 63)),
						COORD_W'($urandom_range(0, 63)), DIR_W'($urandom_range(0, 3)));
					made++;
				end
			end
		end
	endtask

	initial begin
		side_reg = ORDER_RESET;
		target_reg = TARGET_RESET;
		walk_row = '0;
		walk_col = '0;
		seed_grid();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset geometry: rejections, wrapping at every edge, a replaced walker, a stick.
		set_geometry(7'd9, 9'd8);
		queue_walk(OP_STEP, 6'd0, 6'd0, DIR_RIGHT);
		queue_walk(OP_NONE, 6'd63, 6'd63, DIR_DOWN);
		queue_walk(OP_LAUNCH, 6'd4, 6'd4, DIR_RIGHT);
		queue_walk(OP_LAUNCH, 6'd9, 6'd0, DIR_RIGHT);
		queue_walk(OP_LAUNCH, 6'd63, 6'd63, DIR_DOWN);
		queue_walk(OP_LAUNCH, 6'd0, 6'd0, DIR_RIGHT);
		queue_walk(OP_STEP, 6'd0, 6'd0, DIR_UP);
		queue_walk(OP_STEP, 6'd0, 6'd0, DIR_LEFT);
		queue_walk(OP_STEP, 6'd0, 6'd0, DIR_DOWN);
		queue_walk(OP_STEP, 6'd0, 6'd0, DIR_RIGHT);
		queue_walk(OP_LAUNCH, 6'd4, 6'd3, DIR_RIGHT);
		queue_walk(OP_LAUNCH, 6'd3, 6'd4, DIR_RIGHT);
		queue_walk(OP_STEP, 6'd0, 6'd0, DIR_DOWN);
		drain();

		// Smallest grid with a zero target: one stick finishes the run until a clear.
		set_geometry(7'd3, 9'd0);
		queue_walk(OP_CLEAR, 6'd0, 6'd0, DIR_RIGHT);
		queue_walk(OP_LAUNCH, 6'd0, 6'd0, DIR_RIGHT);
		queue_walk(OP_STEP, 6'd0, 6'd0, DIR_RIGHT);
		queue_walk(OP_STEP, 6'd0, 6'd0, DIR_DOWN);
		queue_walk(OP_LAUNCH, 6'd2, 6'd2, DIR_RIGHT);
		queue_walk(OP_STEP, 6'd0, 6'd0, DIR_LEFT);
		drain();

		// Launch far out, then shrink the grid under the walker.
		set_geometry(7'd15, 9'd200);
		queue_walk(OP_CLEAR, 6'd0, 6'd0, DIR_RIGHT);
		queue_walk(OP_LAUNCH, 6'd13, 6'd13, DIR_RIGHT);
		drain();
		set_geometry(7'd5, 9'd200);
		queue_walk(OP_STEP, 6'd0, 6'd0, DIR_UP);
		queue_walk(OP_STEP, 6'd0, 6'd0, DIR_LEFT);
		queue_walk(OP_STEP, 6'd0, 6'd0, DIR_RIGHT);
		queue_walk(OP_STEP, 6'd0, 6'd0, DIR_DOWN);
		drain();

		for (int p = 0; p < 10; p++) begin
			set_geometry(ORDER_W'(phase_side[p]), TARGET_W'(phase_target[p]));
			if (p == 9)
				bursts_on = 1'b0;
			queue_random_walks(phase_items[p]);
			drain();
		end

		if (mismatch_count == 0 && expected_outcomes.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
